[design/dcc_edge_interval_packet_decoder_assert.svh]
// ----------------------------------------------------------------------------
// dcc edge interval packet decoder assertion macros
// concurrent assertion wrappers, empty when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef DCC_EDGE_INTERVAL_PACKET_DECODER_ASSERT_SVH
`define DCC_EDGE_INTERVAL_PACKET_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DCCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DCCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DCCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DCCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/dccd_pkg.sv]
// ----------------------------------------------------------------------------
// dccd_pkg
// shared types and constants of the dcc edge interval packet decoder
// ----------------------------------------------------------------------------
`default_nettype none

package dccd_pkg;

	localparam int LEN_W  = 14;
	localparam int ASYM_W = 8;
	localparam int PRE_W  = 5;
	localparam int BYTE_W = 8;
	localparam int EV_W   = 3;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 14;
	localparam int BCNT_W = 4;

	localparam logic [LEN_W-1:0]  ONE_MIN_RST      = 14'd48;
	localparam logic [LEN_W-1:0]  ONE_MAX_RST      = 14'd68;
	localparam logic [LEN_W-1:0]  ZERO_MIN_RST     = 14'd84;
	localparam logic [LEN_W-1:0]  ZERO_MAX_RST     = 14'd10004;
	localparam logic [ASYM_W-1:0] ASYM_LIMIT_RST   = 8'd8;
	localparam logic [PRE_W-1:0]  PREAMBLE_MIN_RST = 5'd10;
	localparam logic [PRE_W-1:0]  PREAMBLE_SAT     = 5'd31;
	localparam logic [BCNT_W-1:0] BYTE_BITS        = 4'd8;

	typedef enum logic [CIDX_W-1:0] {
		CFG_ONE_MIN      = 3'd0,
		CFG_ONE_MAX      = 3'd1,
		CFG_ZERO_MIN     = 3'd2,
		CFG_ZERO_MAX     = 3'd3,
		CFG_ASYM_LIMIT   = 3'd4,
		CFG_PREAMBLE_MIN = 3'd5
	} cfg_idx_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE     = 3'd0,
		EV_BAD_LEN  = 3'd1,
		EV_MISMATCH = 3'd2,
		EV_ASYM     = 3'd3,
		EV_DATA_BIT = 3'd4,
		EV_BYTE     = 3'd5,
		EV_PKT_OK   = 3'd6,
		EV_PKT_BAD  = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		KIND_ONE  = 2'd0,
		KIND_ZERO = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [LEN_W-1:0]  one_min;
		logic [LEN_W-1:0]  one_max;
		logic [LEN_W-1:0]  zero_min;
		logic [LEN_W-1:0]  zero_max;
		logic [ASYM_W-1:0] asym_limit;
		logic [PRE_W-1:0]  preamble_min;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [LEN_W-1:0] len;
	} half_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

[design/dccd_if.sv]
// ----------------------------------------------------------------------------
// dccd channel interfaces
// valid/ready channels for edge intervals and decoder events
// ----------------------------------------------------------------------------
`default_nettype none

interface dccd_in_if;
	import dccd_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] half_period_us;

	modport source (output valid, output half_period_us, input ready);
	modport sink (input valid, input half_period_us, output ready);
endinterface

interface dccd_out_if;
	import dccd_pkg::*;
	logic              valid;
	logic              ready;
	logic [EV_W-1:0]   event_res;
	logic              bit_value;
	logic [BYTE_W-1:0] byte_value;
	logic [BYTE_W-1:0] check_value;

	modport source (output valid, output event_res, output bit_value, output byte_value,
		output check_value, input ready);
	modport sink (input valid, input event_res, input bit_value, input byte_value,
		input check_value, output ready);
endinterface

`default_nettype wire

[design/dccd_front.sv]
// ----------------------------------------------------------------------------
// dccd_front
// accepts edge intervals and classifies them as one, zero or bad half-bits
// ----------------------------------------------------------------------------
`default_nettype none

module dccd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dccd_pkg::cfg_t cfg,
	dccd_in_if.sink           in_ch,
	input  wire logic         q_full,
	output logic              push,
	output dccd_pkg::half_t   push_data
);
	import dccd_pkg::*;

	logic  valid_s1;
	half_t half_s1;
	half_t half_c;
	logic  is_one;
	logic  is_zero;
	logic  take;

	assign is_one  = (in_ch.half_period_us >= cfg.one_min) &&
		(in_ch.half_period_us <= cfg.one_max);
	assign is_zero = (in_ch.half_period_us >= cfg.zero_min) &&
		(in_ch.half_period_us <= cfg.zero_max);

	always_comb begin
		half_c.len = in_ch.half_period_us;
		priority if (is_one) begin
			half_c.kind = KIND_ONE;
		end else if (is_zero) begin
			half_c.kind = KIND_ZERO;
		end else begin
			half_c.kind = KIND_BAD;
		end
	end

	assign push        = valid_s1 && !q_full;
	assign push_data   = half_s1;
	assign in_ch.ready = !valid_s1 || !q_full;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			half_s1 <= half_c;
		end
	end

endmodule

`default_nettype wire

[design/dccd_queue.sv]
// ----------------------------------------------------------------------------
// dccd_queue
// short fifo of classified half-bits between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dccd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dccd_pkg::half_t push_data,
	input  wire logic           pop,
	output dccd_pkg::half_t     pop_data,
	output dccd_pkg::q_status_t status
);
	import dccd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	half_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign status.full  = (cnt_q == CW'(DEPTH));
	assign status.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/dccd_back.sv]
// ----------------------------------------------------------------------------
// dccd_back
// bit phase tracking, preamble and byte framing, xor check, event register
// ----------------------------------------------------------------------------
`default_nettype none

module dccd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dccd_pkg::cfg_t cfg,
	input  wire dccd_pkg::half_t half,
	input  wire dccd_pkg::q_status_t q_stat,
	output logic                pop,
	dccd_out_if.source          out_ch
);
	import dccd_pkg::*;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_SYNC  = 4'b0010,
		PH_A     = 4'b0100,
		PH_B     = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		FR_SEEK   = 3'b001,
		FR_PRE    = 3'b010,
		FR_PACKET = 3'b100
	} frame_t;

	phase_t            phase_q, phase_n;
	frame_t            frame_q, frame_n;
	logic              prev_bit_q, prev_bit_n;
	logic [LEN_W-1:0]  prev_len_q, prev_len_n;
	logic [PRE_W-1:0]  pre_cnt_q, pre_cnt_n;
	logic [BCNT_W-1:0] bits_left_q, bits_left_n;
	logic [BYTE_W-1:0] shift_q, shift_n;
	logic [BYTE_W-1:0] check_q, check_n;

	logic              out_valid_q;
	event_t            ev_q, ev_n;
	logic              bv_q, bv_n;
	logic [BYTE_W-1:0] byv_q, byv_n;
	logic [BYTE_W-1:0] chk_q;

	logic              bit_c;
	logic [LEN_W-1:0]  diff_c;
	logic              asym_bad;

	assign pop   = !q_stat.empty && (!out_valid_q || out_ch.ready);
	assign bit_c = (half.kind == KIND_ONE);

	assign diff_c   = (half.len > prev_len_q) ? half.len - prev_len_q : prev_len_q - half.len;
	assign asym_bad = diff_c > {{(LEN_W - ASYM_W){1'b0}}, cfg.asym_limit};

	always_comb begin
		phase_n     = phase_q;
		frame_n     = frame_q;
		prev_bit_n  = prev_bit_q;
		prev_len_n  = prev_len_q;
		pre_cnt_n   = pre_cnt_q;
		bits_left_n = bits_left_q;
		shift_n     = shift_q;
		check_n     = check_q;
		ev_n        = EV_NONE;
		bv_n        = 1'b0;
		byv_n       = '0;
		if ((half.kind != KIND_ONE) && (half.kind != KIND_ZERO)) begin
			phase_n = PH_START;
			ev_n    = EV_BAD_LEN;
		end else begin
			unique case (phase_q)
				PH_START: begin
					prev_bit_n = bit_c;
					phase_n    = PH_SYNC;
				end
				PH_SYNC: begin
					if (prev_bit_q != bit_c) begin
						frame_n    = FR_SEEK;
						pre_cnt_n  = '0;
						prev_bit_n = bit_c;
						prev_len_n = half.len;
						phase_n    = PH_B;
					end
				end
				PH_A: begin
					prev_bit_n = bit_c;
					prev_len_n = half.len;
					phase_n    = PH_B;
				end
				PH_B: begin
					if (prev_bit_q != bit_c) begin
						prev_bit_n = bit_c;
						phase_n    = PH_SYNC;
						ev_n       = EV_MISMATCH;
					end else if (bit_c && asym_bad) begin
						phase_n = PH_START;
						ev_n    = EV_ASYM;
					end else begin
						phase_n = PH_A;
						unique case (frame_q)
							FR_PACKET: begin
								if (bits_left_q != '0) begin
									shift_n     = {shift_q[BYTE_W-2:0], bit_c};
									bits_left_n = bits_left_q - 1'b1;
									ev_n        = EV_DATA_BIT;
									bv_n        = bit_c;
								end else if (!bit_c) begin
									byv_n       = shift_q;
									check_n     = check_q ^ shift_q;
									bits_left_n = BYTE_BITS;
									ev_n        = EV_BYTE;
								end else begin
									byv_n   = shift_q;
									ev_n    = (shift_q == check_q) ? EV_PKT_OK : EV_PKT_BAD;
									frame_n = FR_PRE;
								end
							end
							FR_PRE: begin
								if (!bit_c) begin
									frame_n     = FR_PACKET;
									bits_left_n = BYTE_BITS;
									check_n     = '0;
								end
							end
							default: begin
								if (bit_c) begin
									if (pre_cnt_q < PREAMBLE_SAT) begin
										pre_cnt_n = pre_cnt_q + 1'b1;
									end
								end else if (pre_cnt_q >= cfg.preamble_min) begin
									frame_n     = FR_PACKET;
									bits_left_n = BYTE_BITS;
									check_n     = '0;
								end else begin
									pre_cnt_n = '0;
								end
							end
						endcase
					end
				end
				default: begin
					phase_n = PH_START;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			frame_q     <= FR_SEEK;
			prev_bit_q  <= 1'b0;
			prev_len_q  <= '0;
			pre_cnt_q   <= '0;
			bits_left_q <= BYTE_BITS;
			check_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_n;
				frame_q     <= frame_n;
				prev_bit_q  <= prev_bit_n;
				prev_len_q  <= prev_len_n;
				pre_cnt_q   <= pre_cnt_n;
				bits_left_q <= bits_left_n;
				check_q     <= check_n;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q <= shift_n;
			ev_q    <= ev_n;
			bv_q    <= bv_n;
			byv_q   <= byv_n;
			chk_q   <= check_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.event_res   = ev_q;
	assign out_ch.bit_value   = bv_q;
	assign out_ch.byte_value  = byv_q;
	assign out_ch.check_value = chk_q;

endmodule

`default_nettype wire

[design/dcc_edge_interval_packet_decoder.sv]
// ----------------------------------------------------------------------------
// dcc_edge_interval_packet_decoder
// dcc track signal decoder working on measured edge intervals
//
// channel   dir  payload
// in_ch     in   half_period_us (14 bit, microseconds)
// out_ch    out  event_res, bit_value, byte_value, check_value
// cfg       in   cfg_we, cfg_index, cfg_data (plain register writes)
//
// one interval accepted per cycle while the queue is not full, one event per interval
// an accepted interval passes the front stage register, then the queue, then the back
// the queue of QUEUE_DEPTH entries lets front and back stall independently
// arst_n clears phase, framing, check and all valid flags, config to defaults
// ----------------------------------------------------------------------------
`default_nettype none
`include "dcc_edge_interval_packet_decoder_assert.svh"

module dcc_edge_interval_packet_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [dccd_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [dccd_pkg::CDAT_W-1:0]  cfg_data,
	dccd_in_if.sink                           in_ch,
	dccd_out_if.source                        out_ch
);
	import dccd_pkg::*;

	cfg_t      cfg_q;
	logic      q_push;
	logic      q_pop;
	half_t     q_wdata;
	half_t     q_rdata;
	q_status_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_min      <= ONE_MIN_RST;
			cfg_q.one_max      <= ONE_MAX_RST;
			cfg_q.zero_min     <= ZERO_MIN_RST;
			cfg_q.zero_max     <= ZERO_MAX_RST;
			cfg_q.asym_limit   <= ASYM_LIMIT_RST;
			cfg_q.preamble_min <= PREAMBLE_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ONE_MIN:      cfg_q.one_min      <= cfg_data[LEN_W-1:0];
				CFG_ONE_MAX:      cfg_q.one_max      <= cfg_data[LEN_W-1:0];
				CFG_ZERO_MIN:     cfg_q.zero_min     <= cfg_data[LEN_W-1:0];
				CFG_ZERO_MAX:     cfg_q.zero_max     <= cfg_data[LEN_W-1:0];
				CFG_ASYM_LIMIT:   cfg_q.asym_limit   <= cfg_data[ASYM_W-1:0];
				CFG_PREAMBLE_MIN: cfg_q.preamble_min <= cfg_data[PRE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dccd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_ch     (in_ch),
		.q_full    (q_stat.full),
		.push      (q_push),
		.push_data (q_wdata)
	);

	dccd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.status    (q_stat)
	);

	dccd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.half   (q_rdata),
		.q_stat (q_stat),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

	`DCCD_ASSERT_IMP(a_no_overflow, clk, arst_n, q_push, !q_stat.full, "push into full queue")
	`DCCD_ASSERT_IMP(a_no_underflow, clk, arst_n, q_pop, !q_stat.empty, "pop from empty queue")
	`DCCD_ASSERT_NXT(a_push_lands, clk, arst_n, q_push && !q_pop, !q_stat.empty, "push lost")
	`DCCD_ASSERT_IMP(a_bad_len_clean, clk, arst_n, out_ch.valid && (out_ch.event_res == EV_BAD_LEN), (out_ch.byte_value == '0) && !out_ch.bit_value, "bad length event carries data")

endmodule

`default_nettype wire

[tb/dccd_event_checker.sv]
// ----------------------------------------------------------------------------
// dccd_event_checker
// watches the interval and event channels and the register port of the dcc
// decoder, tracks phase, framing and xor check of the decoder itself, and
// compares every event with the one predicted for the oldest open interval
// ----------------------------------------------------------------------------
`default_nettype none

module dccd_event_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [dccd_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [dccd_pkg::CDAT_W-1:0] cfg_data,
	dccd_in_if                               in_ch,
	dccd_out_if                              out_ch,
	output int unsigned                      mismatches,
	output int unsigned                      outstanding,
	output int unsigned                      results_seen,
	output int unsigned                      data_bits,
	output int unsigned                      bytes_done,
	output int unsigned                      packets_good,
	output int unsigned                      packets_bad
);
	timeunit 1ns;
	timeprecision 1ps;
	import dccd_pkg::*;

	typedef enum logic [1:0] {
		LOCK_START  = 2'd0,
		LOCK_SYNC   = 2'd1,
		LOCK_HALF_A = 2'd2,
		LOCK_HALF_B = 2'd3
	} lock_t;

	typedef enum logic [1:0] {
		FRM_SEEK     = 2'd0,
		FRM_PREAMBLE = 2'd1,
		FRM_PACKET   = 2'd2
	} frame_t;

	typedef struct packed {
		event_t            ev;
		logic              bit_v;
		logic [BYTE_W-1:0] byte_v;
		logic [BYTE_W-1:0] chk_v;
	} decoded_t;

	cfg_t              cfg;
	lock_t             lock;
	frame_t            frame;
	logic              last_kind;
	logic [LEN_W-1:0]  first_len;
	logic [PRE_W-1:0]  ones_run;
	logic [BCNT_W-1:0] bits_left;
	logic [BYTE_W-1:0] shreg;
	logic [BYTE_W-1:0] xor_acc;
	decoded_t          expected_events [$];

	function automatic void open_frame();
		frame     = FRM_PACKET;
		bits_left = BYTE_BITS;
		xor_acc   = '0;
	endfunction

	function automatic decoded_t decode_half(input logic [LEN_W-1:0] len);
		decoded_t         r;
		logic             is_one;
		logic [LEN_W-1:0] diff;
		r.ev    = EV_NONE;
		r.bit_v = 1'b0;
		r.byte_v = '0;
		r.chk_v = xor_acc;
		if (len >= cfg.one_min && len <= cfg.one_max) begin
			is_one = 1'b1;
		end else if (len >= cfg.zero_min && len <= cfg.zero_max) begin
			is_one = 1'b0;
		end else begin
			lock = LOCK_START;
			r.ev = EV_BAD_LEN;
			return r;
		end
		if (lock == LOCK_START) begin
			last_kind = is_one;
			lock      = LOCK_SYNC;
			return r;
		end
		if (lock == LOCK_SYNC) begin
			if (last_kind == is_one)
				return r;
			frame    = FRM_SEEK;
			ones_run = '0;
			lock     = LOCK_HALF_A;
		end
		if (lock == LOCK_HALF_A) begin
			last_kind = is_one;
			first_len = len;
			lock      = LOCK_HALF_B;
			return r;
		end
		if (last_kind != is_one) begin
			last_kind = is_one;
			lock      = LOCK_SYNC;
			r.ev      = EV_MISMATCH;
			return r;
		end
		diff = (len > first_len) ? len - first_len : first_len - len;
		if (is_one && diff > cfg.asym_limit) begin
			lock = LOCK_START;
			r.ev = EV_ASYM;
			return r;
		end
		lock = LOCK_HALF_A;
		case (frame)
			FRM_PACKET: begin
				if (bits_left != 0) begin
					shreg = {shreg[BYTE_W-2:0], is_one};
					bits_left--;
					r.ev    = EV_DATA_BIT;
					r.bit_v = is_one;
				end else if (!is_one) begin
					r.byte_v  = shreg;
					xor_acc  ^= shreg;
					bits_left = BYTE_BITS;
					r.ev      = EV_BYTE;
				end else begin
					r.byte_v = shreg;
					r.ev     = (shreg == xor_acc) ? EV_PKT_OK : EV_PKT_BAD;
					frame    = FRM_PREAMBLE;
				end
			end
			FRM_PREAMBLE: begin
				if (!is_one)
					open_frame();
			end
			default: begin
				if (is_one) begin
					if (ones_run < PREAMBLE_SAT)
						ones_run++;
				end else if (ones_run >= cfg.preamble_min) begin
					open_frame();
				end else begin
					ones_run = '0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			cfg = {ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST, ASYM_LIMIT_RST,
				PREAMBLE_MIN_RST};
			lock         = LOCK_START;
			frame        = FRM_SEEK;
			last_kind    = 1'b0;
			first_len    = '0;
			ones_run     = '0;
			bits_left    = BYTE_BITS;
			shreg        = '0;
			xor_acc      = '0;
			mismatches   = 0;
			results_seen = 0;
			data_bits    = 0;
			bytes_done   = 0;
			packets_good = 0;
			packets_bad  = 0;
			expected_events.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ONE_MIN:      cfg.one_min      = cfg_data;
					CFG_ONE_MAX:      cfg.one_max      = cfg_data;
					CFG_ZERO_MIN:     cfg.zero_min     = cfg_data;
					CFG_ZERO_MAX:     cfg.zero_max     = cfg_data;
					CFG_ASYM_LIMIT:   cfg.asym_limit   = cfg_data[ASYM_W-1:0];
					CFG_PREAMBLE_MIN: cfg.preamble_min = cfg_data[PRE_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_events.size() == 0) begin
					$display("%0t: event %0d with no interval open", $time, out_ch.event_res);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					compare_field("event_res", 8'(want.ev), 8'(out_ch.event_res));
					compare_field("bit_value", 8'(want.bit_v), 8'(out_ch.bit_value));
					compare_field("byte_value", want.byte_v, out_ch.byte_value);
					compare_field("check_value", want.chk_v, out_ch.check_value);
					case (want.ev)
						EV_DATA_BIT: data_bits++;
						EV_BYTE:     bytes_done++;
						EV_PKT_OK:   packets_good++;
						EV_PKT_BAD:  packets_bad++;
						default: ;
					endcase
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_events.push_back(decode_half(in_ch.half_period_us));
			outstanding <= expected_events.size();
		end
	end

endmodule

`default_nettype wire

[tb/tb_dcc_edge_interval_packet_decoder.sv]
// ----------------------------------------------------------------------------
// tb_dcc_edge_interval_packet_decoder
// drives edge intervals into the dcc decoder: boundary lengths, packet
// streams with random bytes and good or broken check bytes, and line noise,
// under several register settings and random stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dcc_edge_interval_packet_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import dccd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 64;
	localparam int DRAIN_CYCLES   = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CDAT_W-1:0] cfg_data;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned results_seen;
	int unsigned data_bits;
	int unsigned bytes_done;
	int unsigned packets_good;
	int unsigned packets_bad;

	int unsigned halves_sent    = 0;
	int unsigned settings_used  = 0;
	int unsigned hold_token     = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_idle_pct  = 0;
	cfg_t        stim_cfg;

	dccd_in_if  in_ch ();
	dccd_out_if out_ch ();

	dcc_edge_interval_packet_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	dccd_event_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.data_bits    (data_bits),
		.bytes_done   (bytes_done),
		.packets_good (packets_good),
		.packets_bad  (packets_bad)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// event sink with random stalls and requested long hold-offs
	initial begin : receiver
		int unsigned holds_done;
		holds_done   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != holds_done) begin
				holds_done = hold_token;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic cfg_t make_cfg(input int one_lo, input int one_hi, input int zero_lo,
		input int zero_hi, input int asym, input int pre);
		cfg_t c;
		c.one_min      = LEN_W'(one_lo);
		c.one_max      = LEN_W'(one_hi);
		c.zero_min     = LEN_W'(zero_lo);
		c.zero_max     = LEN_W'(zero_hi);
		c.asym_limit   = ASYM_W'(asym);
		c.preamble_min = PRE_W'(pre);
		return c;
	endfunction

	function automatic cfg_t random_cfg();
		int one_lo, one_hi, zero_lo;
		one_lo  = $urandom_range(80, 20);
		one_hi  = one_lo + int'($urandom_range(40));
		zero_lo = one_hi - 10 + int'($urandom_range(40));
		return make_cfg(one_lo, one_hi, zero_lo, zero_lo + int'($urandom_range(3000, 10)),
			$urandom_range(255), $urandom_range(31, 1));
	endfunction

	function automatic logic [LEN_W-1:0] one_len();
		if (stim_cfg.one_min <= stim_cfg.one_max)
			return LEN_W'($urandom_range(stim_cfg.one_max, stim_cfg.one_min));
		return LEN_W'($urandom_range(16383));
	endfunction

	// second half of a one bit within the allowed asymmetry
	function automatic logic [LEN_W-1:0] one_partner(input logic [LEN_W-1:0] lead_len);
		int lo, hi;
		lo = int'(lead_len) - int'(stim_cfg.asym_limit);
		hi = int'(lead_len) + int'(stim_cfg.asym_limit);
		if (lo < int'(stim_cfg.one_min))
			lo = stim_cfg.one_min;
		if (hi > int'(stim_cfg.one_max))
			hi = stim_cfg.one_max;
		if (lo > hi)
			return lead_len;
		return LEN_W'($urandom_range(hi, lo));
	endfunction

	// zero length kept clear of the one range where possible
	function automatic logic [LEN_W-1:0] zero_len();
		int lo, hi;
		lo = stim_cfg.zero_min;
		hi = stim_cfg.zero_max;
		if (lo > hi)
			return LEN_W'($urandom_range(16383));
		if (stim_cfg.one_min <= stim_cfg.one_max && hi >= int'(stim_cfg.one_min)
			&& lo <= int'(stim_cfg.one_max)) begin
			if (hi > int'(stim_cfg.one_max))
				lo = int'(stim_cfg.one_max) + 1;
			else if (lo < int'(stim_cfg.one_min))
				hi = int'(stim_cfg.one_min) - 1;
		end
		return LEN_W'($urandom_range(hi, lo));
	endfunction

	task automatic send_half(input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.half_period_us <= len;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		halves_sent++;
	endtask

	task automatic send_bit(input logic is_one);
		logic [LEN_W-1:0] lead_len;
		if (is_one) begin
			lead_len = one_len();
			send_half(lead_len);
			send_half(one_partner(lead_len));
		end else begin
			send_half(zero_len());
			send_half(zero_len());
		end
	endtask

	// preamble, opening zero, data bytes with zero separators, check byte, end one
	task automatic send_packet(input int pre_ones, input int nbytes, input bit bad_check);
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] xsum;
		xsum = '0;
		repeat (pre_ones)
			send_bit(1'b1);
		send_bit(1'b0);
		for (int i = 0; i <= nbytes; i++) begin
			if (i < nbytes)
				data = BYTE_W'($urandom);
			else if (bad_check)
				data = xsum ^ (8'd1 << $urandom_range(7));
			else
				data = xsum;
			for (int j = BYTE_W - 1; j >= 0; j--)
				send_bit(data[j]);
			send_bit(i == nbytes);
			xsum ^= data;
		end
	endtask

	task automatic send_noise();
		logic [LEN_W-1:0] lead_len;
		logic [LEN_W-1:0] limits [4];
		limits[0] = stim_cfg.one_min - 1'b1;
		limits[1] = stim_cfg.one_max + 1'b1;
		limits[2] = stim_cfg.zero_min - 1'b1;
		limits[3] = stim_cfg.zero_max + 1'b1;
		case ($urandom_range(3))
			0: send_half(LEN_W'($urandom_range(16383)));
			1: begin
				send_half(one_len());
				send_half(zero_len());
			end
			2: begin
				lead_len = one_len();
				send_half(lead_len);
				send_half(lead_len + stim_cfg.asym_limit + 1'b1);
			end
			default: send_half(limits[2'($urandom_range(3))]);
		endcase
	endtask

	task automatic random_traffic(input int unsigned n);
		int unsigned stop_at;
		int unsigned pick;
		int          pre;
		stop_at = halves_sent + n;
		while (halves_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				if (pick < 4)
					pre = $urandom_range(40, 32);
				else if (pick < 12)
					pre = $urandom_range(stim_cfg.preamble_min);
				else
					pre = stim_cfg.preamble_min + $urandom_range(4);
				send_packet(pre, $urandom_range(3), $urandom_range(9) == 0);
			end else begin
				repeat ($urandom_range(3, 1))
					send_noise();
			end
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CDAT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic program_cfg(input cfg_t c);
		write_reg(CFG_ONE_MIN, c.one_min);
		write_reg(CFG_ONE_MAX, c.one_max);
		write_reg(CFG_ZERO_MIN, c.zero_min);
		write_reg(CFG_ZERO_MAX, c.zero_max);
		write_reg(CFG_ASYM_LIMIT, CDAT_W'(c.asym_limit));
		write_reg(CFG_PREAMBLE_MIN, CDAT_W'(c.preamble_min));
		cfg_we   <= 1'b0;
		stim_cfg  = c;
		settings_used++;
	endtask

	initial begin : stimulus
		int directed_lens [];
		cfg_t reset_cfg;
		directed_lens = '{0, 16383, 48, 48, 84, 10004, 60, 100, 68, 60, 52, 62,
			47, 69, 83, 10005};
		reset_cfg = make_cfg(ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
			ASYM_LIMIT_RST, PREAMBLE_MIN_RST);
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_ONE_MIN;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.half_period_us = '0;
		stim_cfg             = reset_cfg;
		settings_used        = 1;
		send_idle_pct        = 30;
		recv_idle_pct        = 70;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// range limits, sync, mismatch and asymmetry at reset settings
		foreach (directed_lens[i])
			send_half(LEN_W'(directed_lens[i]));
		wait_drained();

		hold_token <= hold_token + 1;
		random_traffic(100);
		wait_drained();

		// zero asymmetry allowed, one-bit preamble
		program_cfg(make_cfg(52, 64, 90, 200, 0, 1));
		random_traffic(50);
		wait_drained();

		send_idle_pct = 70;
		recv_idle_pct = 30;
		// overlapping ranges, widest limits, longest preamble
		program_cfg(make_cfg(0, 100, 50, 16383, 255, 31));
		random_traffic(60);
		wait_drained();

		// empty zero range
		program_cfg(make_cfg(1, 16383, 16383, 0, 255, 31));
		random_traffic(20);
		wait_drained();

		program_cfg(random_cfg());
		random_traffic(30);
		wait_drained();
		random_traffic(30);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_cfg(reset_cfg);
		hold_token <= hold_token + 1;
		random_traffic(80);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d intervals under %0d register settings with stalls on both sides",
			halves_sent, settings_used);
		$display("%0d events: %0d data bits, %0d bytes, %0d packets ok, %0d packets bad",
			results_seen, data_bits, bytes_done, packets_good, packets_bad);
		if (outstanding != 0)
			$display("%0t: %0d events never arrived", $time, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
